[rtl/utt_pkg.sv]
package utt_pkg;

  localparam int MaxBytes = 12;
  localparam int CntW = 4;

  // up to three bytes of one bmp code point, byte 0 goes out first
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] b;
  } enc_t;

  // up to six bytes: a bmp code point, a lone surrogate, or a supplementary code point
  typedef struct packed {
    logic [2:0]      len;
    logic [5:0][7:0] b;
  } seg_t;

  // everything one request produces on the output side
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     end_flag;
  } item_t;

  function automatic enc_t enc_cp16(logic [15:0] cp);
    enc_t e;
    e = '0;
    if (cp < 16'h0080) begin
      e.len  = 2'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      e.len  = 2'd2;
      e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.b[1] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      e.len  = 2'd3;
      e.b[0] = 8'hE0 | {4'h0, cp[15:12]};
      e.b[1] = 8'h80 | {2'b00, cp[11:6]};
      e.b[2] = 8'h80 | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

  function automatic seg_t enc_lone(logic [15:0] u, logic esc);
    seg_t s;
    enc_t e0;
    enc_t e1;
    s  = '0;
    e0 = enc_cp16(16'hDC80 + {8'h00, u[7:0]});
    e1 = enc_cp16(16'hDC80 + {8'h00, u[15:8]});
    if (esc) begin
      s.len      = 3'd6;
      s.b[2:0]   = e0.b;
      s.b[5:3]   = e1.b;
    end else begin
      s.len  = 3'd3;
      s.b[0] = 8'hEF;
      s.b[1] = 8'hBF;
      s.b[2] = 8'hBD;
    end
    return s;
  endfunction

  function automatic seg_t enc_bmp(logic [15:0] cp);
    seg_t s;
    enc_t e;
    s        = '0;
    e        = enc_cp16(cp);
    s.len    = {1'b0, e.len};
    s.b[2:0] = e.b;
    return s;
  endfunction

  function automatic seg_t enc_pair(logic [9:0] hi, logic [9:0] lo);
    seg_t s;
    logic [20:0] cp;
    s      = '0;
    cp     = 21'h010000 + {1'b0, hi, lo};
    s.len  = 3'd4;
    s.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
    s.b[1] = 8'h80 | {2'b00, cp[17:12]};
    s.b[2] = 8'h80 | {2'b00, cp[11:6]};
    s.b[3] = 8'h80 | {2'b00, cp[5:0]};
    return s;
  endfunction

endpackage

[rtl/utt_decode.sv]
module utt_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [15:0]    code_unit,
  input  logic           last_unit,
  input  logic           esc,
  output utt_pkg::item_t item
);
  import utt_pkg::*;

  logic       held_valid;
  logic [9:0] held_low_bits;

  logic is_high;
  logic is_low;
  logic is_sur;
  seg_t seg_a;
  seg_t seg_b;

  assign is_high = code_unit[15:10] == 6'b110110;
  assign is_low  = code_unit[15:10] == 6'b110111;
  assign is_sur  = code_unit[15:11] == 5'b11011;

  always_comb begin
    seg_a = '0;
    seg_b = '0;
    if (held_valid && is_low) begin
      seg_a = enc_pair(held_low_bits, code_unit[9:0]);
    end else begin
      // a held high surrogate without its partner goes out first
      if (held_valid) begin
        seg_a = enc_lone({6'b110110, held_low_bits}, esc);
      end
      if (is_high && !last_unit) begin
        seg_b = '0;
      end else if (is_sur) begin
        seg_b = enc_lone(code_unit, esc);
      end else begin
        seg_b = enc_bmp(code_unit);
      end
    end
  end

  always_comb begin
    item          = '0;
    item.cnt      = {1'b0, seg_a.len} + {1'b0, seg_b.len};
    item.end_flag = last_unit;
    case (seg_a.len)
      3'd3: begin
        item.bytes[2:0] = seg_a.b[2:0];
        item.bytes[8:3] = seg_b.b;
      end
      3'd4: begin
        item.bytes[3:0] = seg_a.b[3:0];
      end
      3'd6: begin
        item.bytes[5:0]  = seg_a.b;
        item.bytes[11:6] = seg_b.b;
      end
      default: begin
        item.bytes[5:0] = seg_b.b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      held_low_bits <= '0;
    end else if (accept) begin
      held_valid    <= is_high && !last_unit;
      held_low_bits <= (is_high && !last_unit) ? code_unit[9:0] : 10'd0;
    end
  end

endmodule

[rtl/utt_serializer.sv]
module utt_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  utt_pkg::item_t item,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           stream_end
);
  import utt_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes;
  logic [CntW-1:0]          rem;
  logic                     end_flag;
  logic                     take;

  assign take      = (rem != '0) && !out_stall;
  assign can_load  = (rem == '0) || ((rem == CntW'(1)) && !out_stall);
  assign out_valid = rem != '0;
  assign out_byte  = bytes[0];
  assign run_last  = rem == CntW'(1);
  assign stream_end = (rem == CntW'(1)) && end_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= item.cnt;
    end else if (take) begin
      rem <= rem - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= item.bytes;
      end_flag <= item.end_flag;
    end else if (take) begin
      bytes <= {8'h00, bytes[MaxBytes-1:1]};
    end
  end

endmodule

[rtl/utf16_to_utf8_transcoder_top.sv]
// a request accepted is loaded into the output shift register and its first byte is offered in the next cycle
// throughput: one byte per cycle while out_stall is low; a request yields
// 1 to 3 bytes for a bmp unit, 4 for a pair, up to 12, sent from the output shift register
// a new request is taken in the cycle its predecessor's last byte is taken
// a high surrogate that is held produces no bytes of its own and leaves the input free
// synchronous active-high reset empties the output and the held surrogate, escape off
module utf16_to_utf8_transcoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import utt_pkg::*;

  logic  surrogate_escape;
  logic  can_load;
  logic  accept;
  item_t item;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign accept    = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      surrogate_escape <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      surrogate_escape <= cfg_data;
    end
  end

  utt_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .esc       (surrogate_escape),
    .item      (item)
  );

  utt_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .item       (item),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule

[rtl/utt_checker.sv]
module utt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_end
);

  // stream end only on the closing byte of a request
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_last)
    else $error("stream_end without run_last");

  // bytes of one request follow each other without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last && !out_stall |=> out_valid)
    else $error("gap inside a byte run");

  // no new request while a run is still open
  a_mid_run_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> in_stall)
    else $error("input taken in the middle of a run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled output byte changed");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input request withdrawn while stalled");

endmodule

bind utf16_to_utf8_transcoder_top utt_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .stream_end (stream_end)
);
